### rtl/ikin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_pkg
// Shared widths, codes, types and the CORDIC arctangent table of the
// two-link planar inverse kinematics unit.
// ----------------------------------------------------------------------------
package ikin_pkg;

   localparam int IN_W             = 20;
   localparam int LINK_W           = 19;
   localparam int ANG_W            = 20;
   localparam int STAT_W           = 2;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 19;
   localparam int CORDIC_STEPS_DEF = 18;
   localparam int RAD_W            = 64;
   localparam int ROOT_W           = 32;
   localparam int OPND_W           = 33;
   localparam int CORD_W           = 35;
   localparam int ACC_W            = 34;
   localparam int NUM_W            = 44;
   localparam int HQ_W             = 36;
   localparam int MUL_W            = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int ATAN_IDX_W       = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 1'b1;

   localparam logic [LINK_W-1:0] LINK_RESET = 19'd16384;

   localparam logic signed [ACC_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_CLAMP  = 2'd1,
      STAT_ORIGIN = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MXX, S_MZZ, S_ML11, S_ML22, S_ML12, S_SQL_GO, S_SQL_WAIT,
      S_MLEN, S_CB_GO, S_CB_WAIT, S_AC_SET, S_AC_MUL, S_AC_SQGO, S_AC_SQWAIT,
      S_AC_CGO, S_AC_CWAIT, S_DONE
   } seq_state_type;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] z;
      logic                   origin;
   } q_item_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [OPND_W-1:0] y;
      logic signed [OPND_W-1:0] x;
   } cordic_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] angle;
   } cordic_rsp_type;

   function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837830;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         5'd24: v = 32'd64;
         5'd25: v = 32'd32;
         5'd26: v = 32'd16;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/ikin_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_if
// Valid/ready channels for target words and joint angle words.
// ----------------------------------------------------------------------------
interface ikin_req_if import ikin_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] target_x;
   logic signed [IN_W-1:0] target_z;
   modport source (output valid, target_x, target_z, input ready);
   modport sink   (input valid, target_x, target_z, output ready);
endinterface

interface ikin_rsp_if import ikin_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ANG_W-1:0] hip_angle;
   logic signed [ANG_W-1:0] knee_angle;
   logic [STAT_W-1:0]       status;
   modport source (output valid, hip_angle, knee_angle, status, input ready);
   modport sink   (input valid, hip_angle, knee_angle, status, output ready);
endinterface

### rtl/two_link_planar_inverse_kinematics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_planar_inverse_kinematics_unit
// Law-of-cosines inverse kinematics for a two-link planar leg.
// ----------------------------------------------------------------------------
// A target word (x, z, Q3.16 metres) returns one word with hip and knee
// angles (Q3.16 radians) and a status: ok, unreachable (clamped) or target at
// origin. A two-entry queue takes targets while the back end works. For a
// reachable target one shared 32-step square-root unit runs three times and
// one CORDIC runs three times, between multiplier and hand-off steps; a
// clamped acos argument skips its square root and CORDIC, and an origin
// target goes straight to its result word. A result word that is not taken
// holds the back end. Link lengths are to be written through the csr port
// only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module two_link_planar_inverse_kinematics_unit import ikin_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ikin_req_if.sink              req,
   ikin_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [LINK_W-1:0] upper_ff, lower_ff;
   logic              q_valid, q_pop;
   q_item_type        q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= LINK_RESET;
         lower_ff <= LINK_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_UPPER: upper_ff <= csr_wdata;
            CSR_LOWER: lower_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ikin_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   ikin_seq #(.CORDIC_STEPS(CORDIC_STEPS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .upper_len (upper_ff),
      .lower_len (lower_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp       (rsp)
   );

endmodule

### rtl/ikin_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_front
// Accepts target words, flags targets at the origin and queues them.
// ----------------------------------------------------------------------------
module ikin_front import ikin_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ikin_req_if.sink    req,
   output logic        q_valid,
   output q_item_type  q_item,
   input  logic        q_pop
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_item_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push, pop;
   q_item_type              new_item;

   assign req.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid & req.ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop & q_valid;
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.x      = req.target_x;
      new_item.z      = req.target_z;
      new_item.origin = (req.target_x == '0) && (req.target_z == '0);
      wr_ptr_in       = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in       = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in        = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### rtl/ikin_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_sqrt
// Integer square root, one result bit per cycle, restoring form.
// ----------------------------------------------------------------------------
module ikin_sqrt import ikin_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type sq_req,
   output sqrt_rsp_type sq_rsp
);
   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], val_ff[RAD_W-1:RAD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (sq_req.start) begin
         val_in  = sq_req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = val_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = root_ff;

endmodule

### rtl/ikin_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_cordic
// Vectoring CORDIC for atan2(y, x) in Q30 radians, one step per cycle.
// ----------------------------------------------------------------------------
module ikin_cordic import ikin_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type co_req,
   output cordic_rsp_type co_rsp
);
   localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(STEPS - 1);

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, xn, yn, xs, ys;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, step_ang;
   logic [ATAN_IDX_W-1:0]    i_ff, i_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic signed [OPND_W-1:0] ax_s, ay_s;
   logic [31:0]              mag;
   logic [5:0]               blen, shamt;

   always_comb begin
      ax_s = co_req.x[OPND_W-1] ? -co_req.x : co_req.x;
      ay_s = co_req.y[OPND_W-1] ? -co_req.y : co_req.y;
      mag  = ax_s[31:0] | ay_s[31:0];
      blen = '0;
      for (int b = 0; b < 32; b++) begin
         if (mag[b]) begin
            blen = 6'(b + 1);
         end
      end
      shamt = (blen < 6'd30) ? 6'd30 - blen : 6'd0;
      xn    = CORD_W'(co_req.x) <<< shamt;
      yn    = CORD_W'(co_req.y) <<< shamt;
      xs    = x_ff >>> i_ff;
      ys    = y_ff >>> i_ff;
      step_ang = ACC_W'({2'b00, atan_q30(i_ff)});

      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (co_req.start) begin
         i_in = '0;
         priority if (mag == '0) begin
            acc_in  = '0;
            done_in = 1'b1;
         end else if (xn < 0 && yn >= 0) begin
            x_in    = yn;
            y_in    = -xn;
            acc_in  = HALF_PI_Q30;
            busy_in = 1'b1;
         end else if (xn < 0) begin
            x_in    = -yn;
            y_in    = xn;
            acc_in  = -HALF_PI_Q30;
            busy_in = 1'b1;
         end else begin
            x_in    = xn;
            y_in    = yn;
            acc_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            acc_in = acc_ff + step_ang;
         end else begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            acc_in = acc_ff - step_ang;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign co_rsp.done  = done_ff;
   assign co_rsp.angle = acc_ff;

endmodule

### rtl/ikin_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikin_seq
// Back end: sequences the shared multiplier, square root and CORDIC over one
// target and holds the finished angle word for the result channel.
// ----------------------------------------------------------------------------
module ikin_seq import ikin_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [LINK_W-1:0] upper_len,
   input  logic [LINK_W-1:0] lower_len,
   input  logic              q_valid,
   input  q_item_type        q_item,
   output logic              q_pop,
   ikin_rsp_if.source        rsp
);
   seq_state_type state_ff, state_in;

   logic signed [IN_W-1:0]  x_ff, z_ff;
   logic [IN_W-1:0]         ax, az;
   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [2*MUL_W-1:0]      prod_ff;
   logic [40:0]             sq_ff;
   logic [37:0]             l11_ff, l22_ff, l12_ff;
   logic [20:0]             len_ff;
   logic signed [NUM_W-1:0] nh_ff, dh_ff, nk_ff, dk_ff, n_sel, d_sel, n_sh, d_sh;
   logic signed [31:0]      an_ff, ad_ff, an_c, ad_c;
   logic signed [HQ_W-1:0]  hip_ff, knee_ff, hip_rnd, knee_rnd;
   logic                    which_ff;
   status_type              stat_ff;
   logic                    ac_special;
   logic signed [ACC_W-1:0] ac_val;
   logic [5:0]              d_blen, d_shamt;
   logic                    out_valid_ff;
   logic signed [ANG_W-1:0] hip_out_ff, knee_out_ff;
   status_type              stat_out_ff;
   logic                    slot_free;
   sqrt_req_type            sq_req;
   sqrt_rsp_type            sq_rsp;
   cordic_req_type          co_req;
   cordic_rsp_type          co_rsp;

   ikin_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   ikin_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .co_req (co_req),
      .co_rsp (co_rsp)
   );

   assign slot_free = !out_valid_ff || rsp.ready;
   assign ax        = x_ff[IN_W-1] ? IN_W'(-x_ff) : IN_W'(x_ff);
   assign az        = z_ff[IN_W-1] ? IN_W'(-z_ff) : IN_W'(z_ff);

   // acos argument classification and scaling
   always_comb begin
      n_sel  = which_ff ? nk_ff : nh_ff;
      d_sel  = which_ff ? dk_ff : dh_ff;
      d_blen = '0;
      for (int b = 0; b < NUM_W; b++) begin
         if (d_sel[b]) begin
            d_blen = 6'(b + 1);
         end
      end
      d_shamt    = (d_blen > 6'd30) ? d_blen - 6'd30 : 6'd0;
      d_sh       = d_sel >>> d_shamt;
      n_sh       = n_sel >>> d_shamt;
      ad_c       = d_sh[31:0];
      an_c       = (n_sh < -d_sh) ? -d_sh[31:0] : n_sh[31:0];
      ac_special = (d_sel <= 0) || (n_sel > d_sel) || (n_sel < -d_sel);
      priority if (d_sel <= 0) begin
         ac_val = (n_sel >= 0) ? '0 : PI_Q30;
      end else if (n_sel > d_sel) begin
         ac_val = '0;
      end else begin
         ac_val = PI_Q30;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (q_valid) state_in = q_item.origin ? S_DONE : S_MXX;
         S_MXX:       state_in = S_MZZ;
         S_MZZ:       state_in = S_ML11;
         S_ML11:      state_in = S_ML22;
         S_ML22:      state_in = S_ML12;
         S_ML12:      state_in = S_SQL_GO;
         S_SQL_GO:    state_in = S_SQL_WAIT;
         S_SQL_WAIT:  if (sq_rsp.done) state_in = S_MLEN;
         S_MLEN:      state_in = S_CB_GO;
         S_CB_GO:     state_in = S_CB_WAIT;
         S_CB_WAIT:   if (co_rsp.done) state_in = S_AC_SET;
         S_AC_SET: begin
            if (!ac_special) state_in = S_AC_MUL;
            else if (which_ff) state_in = S_DONE;
         end
         S_AC_MUL:    state_in = S_AC_SQGO;
         S_AC_SQGO:   state_in = S_AC_SQWAIT;
         S_AC_SQWAIT: if (sq_rsp.done) state_in = S_AC_CGO;
         S_AC_CGO:    state_in = S_AC_CWAIT;
         S_AC_CWAIT:  if (co_rsp.done) state_in = which_ff ? S_DONE : S_AC_SET;
         S_DONE:      if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      q_pop           = 1'b0;
      mul_a           = '0;
      mul_b           = '0;
      sq_req.start    = 1'b0;
      sq_req.radicand = prod_ff;
      co_req.start    = 1'b0;
      co_req.y        = OPND_W'(x_ff);
      co_req.x        = -OPND_W'(z_ff);
      unique case (state_ff)
         S_IDLE:   q_pop = q_valid;
         S_MXX:    begin mul_a = MUL_W'(ax); mul_b = MUL_W'(ax); end
         S_MZZ:    begin mul_a = MUL_W'(az); mul_b = MUL_W'(az); end
         S_ML11:   begin mul_a = MUL_W'(upper_len); mul_b = MUL_W'(upper_len); end
         S_ML22:   begin mul_a = MUL_W'(lower_len); mul_b = MUL_W'(lower_len); end
         S_ML12:   begin mul_a = MUL_W'(upper_len); mul_b = MUL_W'(lower_len); end
         S_SQL_GO: begin
            sq_req.start    = 1'b1;
            sq_req.radicand = RAD_W'(sq_ff);
         end
         S_MLEN:   begin mul_a = MUL_W'(len_ff); mul_b = MUL_W'(upper_len); end
         S_CB_GO:  co_req.start = 1'b1;
         S_AC_MUL: begin
            mul_a = MUL_W'(ad_ff - an_ff);
            mul_b = MUL_W'(ad_ff + an_ff);
         end
         S_AC_SQGO: sq_req.start = 1'b1;
         S_AC_CGO: begin
            co_req.start = 1'b1;
            co_req.y     = OPND_W'({1'b0, sq_rsp.root});
            co_req.x     = OPND_W'(an_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && slot_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         S_IDLE: begin
            x_ff     <= q_item.x;
            z_ff     <= q_item.z;
            hip_ff   <= '0;
            knee_ff  <= '0;
            which_ff <= 1'b0;
            stat_ff  <= q_item.origin ? STAT_ORIGIN : STAT_OK;
         end
         S_MZZ:      sq_ff  <= 41'(prod_ff);
         S_ML11:     sq_ff  <= sq_ff + 41'(prod_ff);
         S_ML22:     l11_ff <= 38'(prod_ff);
         S_ML12:     l22_ff <= 38'(prod_ff);
         S_SQL_GO:   l12_ff <= 38'(prod_ff);
         S_SQL_WAIT: if (sq_rsp.done) len_ff <= 21'(sq_rsp.root);
         S_CB_GO: begin
            dh_ff <= NUM_W'({prod_ff[41:0], 1'b0});
            nh_ff <= NUM_W'(sq_ff) + NUM_W'(l11_ff) - NUM_W'(l22_ff);
            nk_ff <= NUM_W'(l11_ff) + NUM_W'(l22_ff) - NUM_W'(sq_ff);
            dk_ff <= NUM_W'({l12_ff, 1'b0});
         end
         S_CB_WAIT: if (co_rsp.done) begin
            hip_ff  <= -HQ_W'(co_rsp.angle);
            knee_ff <= -HQ_W'(PI_Q30);
         end
         S_AC_SET: begin
            an_ff <= an_c;
            ad_ff <= ad_c;
            if (ac_special) begin
               stat_ff  <= STAT_CLAMP;
               which_ff <= 1'b1;
               if (which_ff) knee_ff <= knee_ff + HQ_W'(ac_val);
               else          hip_ff  <= hip_ff + HQ_W'(ac_val);
            end
         end
         S_AC_CWAIT: if (co_rsp.done) begin
            which_ff <= 1'b1;
            if (which_ff) knee_ff <= knee_ff + HQ_W'(co_rsp.angle);
            else          hip_ff  <= hip_ff + HQ_W'(co_rsp.angle);
         end
         S_DONE: if (slot_free) begin
            hip_out_ff  <= hip_rnd[ANG_W+13:14];
            knee_out_ff <= knee_rnd[ANG_W+13:14];
            stat_out_ff <= stat_ff;
         end
         default: ;
      endcase
   end

   assign hip_rnd        = hip_ff + HQ_W'(8192);
   assign knee_rnd       = knee_ff + HQ_W'(8192);
   assign rsp.valid      = out_valid_ff;
   assign rsp.hip_angle  = hip_out_ff;
   assign rsp.knee_angle = knee_out_ff;
   assign rsp.status     = stat_out_ff;

`ifndef SYNTHESIS
   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && stat_out_ff == STAT_ORIGIN) |->
      (hip_out_ff == '0 && knee_out_ff == '0))
      else $error("origin word with non-zero angles");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("queue popped while busy");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_valid_ff && !rsp.ready) |=> (state_ff == S_DONE))
      else $error("result word overwritten");
`endif

endmodule
